// ===== rtl/rotate_point_3d_assert.svh =====
// assertion macros for the rotate_point_3d block
`ifndef ROTATE_POINT_3D_ASSERT_SVH
`define ROTATE_POINT_3D_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define RP3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define RP3_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/rp3_pkg.sv =====
// shared types and constants for the rotate_point_3d block
`default_nettype none
package rp3_pkg;
    localparam int FRAC_BITS = 16;
    localparam int TRIG_FRAC = 30;
    localparam int ANG_WIDTH = 32;
    localparam int TRIG_WIDTH = 32;
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

    typedef enum logic [1:0] {
        KIND_ROT_X  = 2'd0,
        KIND_ROT_Y  = 2'd1,
        KIND_ROT_Z  = 2'd2,
        KIND_MATRIX = 2'd3
    } kind_t;

    localparam logic [2:0] REG_MAT_00 = 3'd0;
    localparam logic [2:0] REG_MAT_01 = 3'd1;
    localparam logic [2:0] REG_MAT_02 = 3'd2;
    localparam logic [2:0] REG_MAT_11 = 3'd3;
    localparam logic [2:0] REG_MAT_12 = 3'd4;
    localparam logic [2:0] REG_MAT_22 = 3'd5;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/rp3_cordic.sv =====
// pipelined cordic sine and cosine, one stage per iteration
`default_nettype none
module rp3_cordic
    import rp3_pkg::*;
#(
    parameter int STAGES = 20,
    parameter int PW = 128
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [ANG_WIDTH-1:0]  angle,
    input  wire logic [PW-1:0]         in_pay,
    output logic                       out_valid,
    output logic signed [TRIG_WIDTH+1:0] cos_val,
    output logic signed [TRIG_WIDTH+1:0] sin_val,
    output logic [PW-1:0]              out_pay
);
    localparam int N = (STAGES < 32) ? STAGES : 32;
    localparam int W = TRIG_WIDTH + 2;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [ANG_WIDTH:0] z_reg [0:N];
    logic                flip_reg [0:N];
    logic [N:0]          v_reg;
    logic [PW-1:0]       pay_reg [0:N];

    logic [1:0]          quad;
    logic [ANG_WIDTH-1:0] red;
    assign quad = angle[ANG_WIDTH-1 -: 2];
    assign red = (quad == 2'd1 || quad == 2'd2) ? angle - 32'h80000000 : angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= W'(CORDIC_GAIN);
            y_reg[0]    <= '0;
            z_reg[0]    <= {red[ANG_WIDTH-1], red};
            flip_reg[0] <= (quad == 2'd1 || quad == 2'd2);
            pay_reg[0]  <= in_pay;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [31:0] at;
        assign at = atan_entry(5'(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ANG_WIDTH])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({1'b0, at});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({1'b0, at});
                end
                flip_reg[i+1] <= flip_reg[i];
                pay_reg[i+1]  <= pay_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign cos_val   = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_val   = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign out_pay   = pay_reg[N];
endmodule
`default_nettype wire

// ===== rtl/rp3_mac.sv =====
// product, sum, round and saturate pipeline for both rotation and matrix
`default_nettype none
module rp3_mac
    import rp3_pkg::*;
#(
    parameter int CW = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           kind,
    input  wire logic signed [CW-1:0] px,
    input  wire logic signed [CW-1:0] py,
    input  wire logic signed [CW-1:0] pz,
    input  wire logic signed [TRIG_WIDTH+1:0] c,
    input  wire logic signed [TRIG_WIDTH+1:0] s,
    input  wire logic signed [31:0]   m00,
    input  wire logic signed [31:0]   m01,
    input  wire logic signed [31:0]   m02,
    input  wire logic signed [31:0]   m11,
    input  wire logic signed [31:0]   m12,
    input  wire logic signed [31:0]   m22,
    output logic                      out_valid,
    output logic signed [CW-1:0]      ox,
    output logic signed [CW-1:0]      oy,
    output logic signed [CW-1:0]      oz,
    output logic                      sat
);
    localparam int KW = TRIG_WIDTH + 2;
    localparam int PWD = CW + KW;
    localparam int SW = PWD + 2;

    logic signed [KW-1:0] k_reg [0:8];
    logic signed [CW-1:0] p_reg [0:8];
    logic signed [KW-1:0] k_next [0:8];
    logic signed [CW-1:0] p_next [0:8];
    logic signed [PWD-1:0] prod_reg [0:8];
    logic signed [SW-1:0] sum_reg [0:2];
    logic [1:0] kind1_reg, kind2_reg, kind3_reg;
    logic signed [CW-1:0] px1_reg, py1_reg, pz1_reg, px2_reg, py2_reg, pz2_reg;
    logic signed [CW-1:0] px3_reg, py3_reg, pz3_reg;
    logic [3:0] v_reg;
    logic signed [KW-1:0] ns;
    logic signed [CW-1:0] r_next [0:2];
    logic [2:0] sat_next;
    logic signed [CW-1:0] o_reg [0:2];
    logic sat_reg;
    assign ns = -s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // stage 1: coefficient select
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            k_next[i] = '0;
            p_next[i] = '0;
        end
        case (kind)
            KIND_ROT_X:
            begin
                k_next[0] = c;  p_next[0] = py; k_next[1] = ns; p_next[1] = pz;
                k_next[3] = s;  p_next[3] = py; k_next[4] = c;  p_next[4] = pz;
            end
            KIND_ROT_Y:
            begin
                k_next[0] = c;  p_next[0] = px; k_next[1] = s;  p_next[1] = pz;
                k_next[3] = ns; p_next[3] = px; k_next[4] = c;  p_next[4] = pz;
            end
            KIND_ROT_Z:
            begin
                k_next[0] = c;  p_next[0] = px; k_next[1] = ns; p_next[1] = py;
                k_next[3] = s;  p_next[3] = px; k_next[4] = c;  p_next[4] = py;
            end
            default:
            begin
                k_next[0] = KW'(m00); p_next[0] = px;
                k_next[1] = KW'(m01); p_next[1] = py;
                k_next[2] = KW'(m02); p_next[2] = pz;
                k_next[3] = KW'(m01); p_next[3] = px;
                k_next[4] = KW'(m11); p_next[4] = py;
                k_next[5] = KW'(m12); p_next[5] = pz;
                k_next[6] = KW'(m02); p_next[6] = px;
                k_next[7] = KW'(m12); p_next[7] = py;
                k_next[8] = KW'(m22); p_next[8] = pz;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            px1_reg <= px; py1_reg <= py; pz1_reg <= pz;
            for (int i = 0; i < 9; i++)
            begin
                k_reg[i] <= k_next[i];
                p_reg[i] <= p_next[i];
            end
        end
    end

    // stage 2: products, stage 3: sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= PWD'(k_reg[i]) * PWD'(p_reg[i]);
            end
            kind2_reg <= kind1_reg;
            px2_reg <= px1_reg; py2_reg <= py1_reg; pz2_reg <= pz1_reg;
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= SW'(prod_reg[3*r]) + SW'(prod_reg[3*r+1])
                              + SW'(prod_reg[3*r+2]);
            end
            kind3_reg <= kind2_reg;
            px3_reg <= px2_reg; py3_reg <= py2_reg; pz3_reg <= pz2_reg;
        end
    end

    // stage 4: round, saturate, steer
    always_comb
    begin
        logic signed [SW-1:0] rnd [0:2];
        logic signed [SW-1:0] sh [0:2];
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        logic signed [CW-1:0] v [0:2];
        logic [2:0] f;
        mx = SW'({1'b0, {(CW-1){1'b1}}});
        mn = -mx - SW'(1);
        for (int r = 0; r < 3; r++)
        begin
            if (kind3_reg == KIND_MATRIX)
            begin
                rnd[r] = sum_reg[r] + (SW'(1) <<< (FRAC_BITS - 1));
                sh[r] = rnd[r] >>> FRAC_BITS;
            end
            else
            begin
                rnd[r] = sum_reg[r] + (SW'(1) <<< (TRIG_FRAC - 1));
                sh[r] = rnd[r] >>> TRIG_FRAC;
            end
            if (sh[r] > mx)
            begin
                v[r] = mx[CW-1:0]; f[r] = 1'b1;
            end
            else if (sh[r] < mn)
            begin
                v[r] = mn[CW-1:0]; f[r] = 1'b1;
            end
            else
            begin
                v[r] = sh[r][CW-1:0]; f[r] = 1'b0;
            end
        end
        r_next[0] = px3_reg; r_next[1] = py3_reg; r_next[2] = pz3_reg;
        sat_next = '0;
        case (kind3_reg)
            KIND_ROT_X:
            begin
                r_next[1] = v[0]; r_next[2] = v[1]; sat_next = {1'b0, f[1:0]};
            end
            KIND_ROT_Y:
            begin
                r_next[0] = v[0]; r_next[2] = v[1]; sat_next = {1'b0, f[1:0]};
            end
            KIND_ROT_Z:
            begin
                r_next[0] = v[0]; r_next[1] = v[1]; sat_next = {1'b0, f[1:0]};
            end
            default:
            begin
                r_next[0] = v[0]; r_next[1] = v[1]; r_next[2] = v[2]; sat_next = f;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                o_reg[r] <= r_next[r];
            end
            sat_reg <= |sat_next;
        end
    end

    assign out_valid = v_reg[3];
    assign ox = o_reg[0];
    assign oy = o_reg[1];
    assign oz = o_reg[2];
    assign sat = sat_reg;
endmodule
`default_nettype wire

// ===== rtl/rotate_point_3d.sv =====
// top level of the 3d point rotation and matrix transform block
//
// usage:
//   s_axis carries one point per item: x, y, z and a binary angle in tdata
//   (2^32 is one full turn) and the kind in tuser. kind selects rotation
//   about x, y or z or a multiply by the symmetric matrix held in six
//   config registers. m_axis returns the point in tdata and the saturation
//   flag in tuser. cfg writes register index cfg_index with cfg_data;
//   indexes above five are ignored. write config only while no item is in flight.
// timing:
//   one item per cycle sustained while the output is not stalled. a result
//   passes, once its item is accepted, through one input stage and one per
//   iteration in the cordic (at most 32 cordic stages are used), then
//   select, multiply, sum and round stages.
// reset:
//   the pipeline empties and the matrix returns to identity.
// stall:
//   while a result waits with m_axis_tready low the whole pipeline holds
//   and s_axis_tready is low.
`default_nettype none
module rotate_point_3d
    import rp3_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int CORDIC_STAGES = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // in_x, in_y, in_z, angle from bit 0 up, zero padded
    input  wire logic [((3*COORD_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  wire logic [1:0] s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // out_x, out_y, out_z from bit 0 up, zero padded
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic             m_axis_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    `include "rotate_point_3d_assert.svh"

    localparam int OW = ((3*COORD_WIDTH+7)/8)*8;
    localparam int PW = 2 + 3*COORD_WIDTH;

    logic signed [31:0] mat_reg [0:5];
    logic en;
    logic cv, mv, msat;
    logic signed [TRIG_WIDTH+1:0] cc, ss;
    logic [PW-1:0] cpay;
    logic signed [COORD_WIDTH-1:0] mx, my, mz;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 32'sd65536; mat_reg[1] <= '0; mat_reg[2] <= '0;
            mat_reg[3] <= 32'sd65536; mat_reg[4] <= '0; mat_reg[5] <= 32'sd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAT_00: mat_reg[0] <= cfg_data;
                REG_MAT_01: mat_reg[1] <= cfg_data;
                REG_MAT_02: mat_reg[2] <= cfg_data;
                REG_MAT_11: mat_reg[3] <= cfg_data;
                REG_MAT_12: mat_reg[4] <= cfg_data;
                REG_MAT_22: mat_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    rp3_cordic #(.STAGES(CORDIC_STAGES), .PW(PW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .angle(s_axis_tdata[3*COORD_WIDTH +: 32]),
        .in_pay({s_axis_tdata[3*COORD_WIDTH-1:0], s_axis_tuser}),
        .out_valid(cv), .cos_val(cc), .sin_val(ss), .out_pay(cpay)
    );

    rp3_mac #(.CW(COORD_WIDTH)) u_mac (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv),
        .kind(cpay[1:0]),
        .px(cpay[2 +: COORD_WIDTH]),
        .py(cpay[2+COORD_WIDTH +: COORD_WIDTH]),
        .pz(cpay[2+2*COORD_WIDTH +: COORD_WIDTH]),
        .c(cc), .s(ss),
        .m00(mat_reg[0]), .m01(mat_reg[1]), .m02(mat_reg[2]),
        .m11(mat_reg[3]), .m12(mat_reg[4]), .m22(mat_reg[5]),
        .out_valid(mv), .ox(mx), .oy(my), .oz(mz), .sat(msat)
    );

    assign m_axis_tvalid = mv;
    assign m_axis_tdata = OW'({mz, my, mx});
    assign m_axis_tuser = msat;

    `RP3_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
        "input stalled with empty output")
    `RP3_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed during stall")
    `RP3_ASSERT_NEXT(a_flag_hold_on_stall, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tuser), "saturation flag changed during stall")
    `RP3_ASSERT(a_ready_on_drain, m_axis_tready |-> s_axis_tready,
        "input stalled while output drains")
endmodule
`default_nettype wire
